### rtl/segint_pkg.sv
`default_nettype none
package segint_pkg;
    localparam int CoordBits = 16;
    localparam int FracBits  = 16;
    localparam int DiffBits  = CoordBits + 1;
    localparam int ProdBits  = 2 * DiffBits;
    localparam int CrossBits = ProdBits + 1;
    localparam int QuotBits  = FracBits + 2;
    localparam int MulBits   = QuotBits + 1 + DiffBits;
    localparam int SumBits   = MulBits + CoordBits;

    typedef enum logic [1:0] {
        OUT_NONE    = 2'd0,
        OUT_CROSS   = 2'd1,
        OUT_SHARED  = 2'd2,
        OUT_REFUSED = 2'd3
    } outcome_t;

    typedef struct packed {
        logic signed [CoordBits-1:0] a_start_x;
        logic signed [CoordBits-1:0] a_start_y;
        logic signed [CoordBits-1:0] a_end_x;
        logic signed [CoordBits-1:0] a_end_y;
        logic signed [CoordBits-1:0] b_start_x;
        logic signed [CoordBits-1:0] b_start_y;
        logic signed [CoordBits-1:0] b_end_x;
        logic signed [CoordBits-1:0] b_end_y;
    } seg_in_t;

    typedef struct packed {
        outcome_t           outcome;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } seg_out_t;

    // front to back: classified item
    typedef struct packed {
        logic                        divide;
        outcome_t                    outcome;
        logic unsigned [CrossBits-1:0] tn;
        logic unsigned [CrossBits-1:0] d;
        logic signed [CoordBits-1:0] base_x;
        logic signed [CoordBits-1:0] base_y;
        logic signed [DiffBits-1:0]  adx;
        logic signed [DiffBits-1:0]  ady;
    } seg_job_t;
endpackage
`default_nettype wire

### rtl/segment_intersection.sv
`default_nettype none
// Segment pair intersection, fully pipelined.
// Command channel: present a transaction on item with start high; it is
//   taken at any edge where busy is low. busy is tied low: a new pair can
//   be accepted every cycle.
// Result channel: done pulses for one cycle with result holding outcome
//   and the fixed-point point (16 fraction bits). The receiver cannot
//   stall, so results are never held.
// Pipeline: 3 front stages (differences, 17x17 products, classify), then
//   17 divider stages (one quotient bit each of tn/d), one multiply stage
//   and one output stage.
// Throughput: one transaction per cycle, set by the one-bit-per-stage
//   divider pipeline.
// Config: cfg_valid/cfg_ready writes closed_segments (bit 0 of cfg_data);
//   cfg_ready is always high. Write only while no transaction is in flight.
// Reset: closed_segments returns to 1, all valid flags clear.
module segment_intersection (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire segint_pkg::seg_in_t  item,
    output logic                      done,
    output segint_pkg::seg_out_t      result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_data
);
    logic closed_reg;
    logic job_valid;
    segint_pkg::seg_job_t job;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            closed_reg <= cfg_data;
        end
    end

    segint_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_item   (item),
        .closed    (closed_reg),
        .job_valid (job_valid),
        .job       (job)
    );

    segint_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .res_valid (done),
        .res       (result)
    );
endmodule
`default_nettype wire

### rtl/segint_front.sv
`default_nettype none
// Front: differences, cross products, classification. Three registered stages.
module segint_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire segint_pkg::seg_in_t in_item,
    input  wire logic                closed,
    output logic                     job_valid,
    output segint_pkg::seg_job_t     job
);
    localparam int DB = segint_pkg::DiffBits;
    localparam int PB = segint_pkg::ProdBits;
    localparam int CB = segint_pkg::CrossBits;

    // stage 1: differences
    logic                    v1_reg;
    segint_pkg::seg_in_t     i1_reg;
    logic signed [DB-1:0] adx1_reg, ady1_reg, bdx1_reg, bdy1_reg, ox1_reg, oy1_reg;
    logic signed [DB-1:0] bax_reg, bay_reg, eax_reg, eay_reg, abx_reg, aby_reg;

    function automatic logic signed [DB-1:0] sub(input logic signed [DB-2:0] a,
                                                 input logic signed [DB-2:0] b);
        sub = DB'(a) - DB'(b);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        i1_reg   <= in_item;
        adx1_reg <= sub(in_item.a_end_x, in_item.a_start_x);
        ady1_reg <= sub(in_item.a_end_y, in_item.a_start_y);
        bdx1_reg <= sub(in_item.b_end_x, in_item.b_start_x);
        bdy1_reg <= sub(in_item.b_end_y, in_item.b_start_y);
        ox1_reg  <= sub(in_item.a_start_x, in_item.b_start_x);
        oy1_reg  <= sub(in_item.a_start_y, in_item.b_start_y);
        bax_reg  <= sub(in_item.b_start_x, in_item.a_start_x);
        bay_reg  <= sub(in_item.b_start_y, in_item.a_start_y);
        eax_reg  <= sub(in_item.b_end_x, in_item.a_start_x);
        eay_reg  <= sub(in_item.b_end_y, in_item.a_start_y);
        abx_reg  <= sub(in_item.a_start_x, in_item.b_start_x);
        aby_reg  <= sub(in_item.a_start_y, in_item.b_start_y);
    end

    // stage 2: products (each 17x17)
    logic                 v2_reg;
    segint_pkg::seg_in_t  i2_reg;
    logic signed [DB-1:0] adx2_reg, ady2_reg;
    logic signed [PB-1:0] p_reg [12];

    function automatic logic signed [PB-1:0] mul(input logic signed [DB-1:0] a,
                                                 input logic signed [DB-1:0] b);
        mul = PB'(a) * PB'(b);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        i2_reg   <= i1_reg;
        adx2_reg <= adx1_reg;
        ady2_reg <= ady1_reg;
        p_reg[0]  <= mul(bdy1_reg, adx1_reg);
        p_reg[1]  <= mul(bdx1_reg, ady1_reg);
        p_reg[2]  <= mul(bdx1_reg, oy1_reg);
        p_reg[3]  <= mul(bdy1_reg, ox1_reg);
        p_reg[4]  <= mul(adx1_reg, oy1_reg);
        p_reg[5]  <= mul(ady1_reg, ox1_reg);
        // b_start on A, b_end on A, a_start on B
        p_reg[6]  <= mul(adx1_reg, bay_reg);
        p_reg[7]  <= mul(ady1_reg, bax_reg);
        p_reg[8]  <= mul(adx1_reg, eay_reg);
        p_reg[9]  <= mul(ady1_reg, eax_reg);
        p_reg[10] <= mul(bdx1_reg, aby_reg);
        p_reg[11] <= mul(bdy1_reg, abx_reg);
    end

    // stage 3: sums, sign fix, classification
    logic signed [CB-1:0] d_s, tn_s, sn_s, d_a, tn_a, sn_a;
    logic on_bs, on_be, on_as, hit, edge_t;
    logic signed [segint_pkg::CoordBits-1:0] qx, qy;
    segint_pkg::seg_job_t job_next;

    function automatic logic in_span(input logic signed [segint_pkg::CoordBits-1:0] p,
                                     input logic signed [segint_pkg::CoordBits-1:0] s,
                                     input logic signed [segint_pkg::CoordBits-1:0] e);
        in_span = (p >= s && p <= e) || (p >= e && p <= s);
    endfunction

    always_comb
    begin
        d_s  = CB'(p_reg[0]) - CB'(p_reg[1]);
        tn_s = CB'(p_reg[2]) - CB'(p_reg[3]);
        sn_s = CB'(p_reg[4]) - CB'(p_reg[5]);
        d_a  = d_s[CB-1] ? -d_s : d_s;
        tn_a = d_s[CB-1] ? -tn_s : tn_s;
        sn_a = d_s[CB-1] ? -sn_s : sn_s;
        on_bs = (p_reg[6] == p_reg[7])
              && in_span(i2_reg.b_start_x, i2_reg.a_start_x, i2_reg.a_end_x)
              && in_span(i2_reg.b_start_y, i2_reg.a_start_y, i2_reg.a_end_y);
        on_be = (p_reg[8] == p_reg[9])
              && in_span(i2_reg.b_end_x, i2_reg.a_start_x, i2_reg.a_end_x)
              && in_span(i2_reg.b_end_y, i2_reg.a_start_y, i2_reg.a_end_y);
        on_as = (p_reg[10] == p_reg[11])
              && in_span(i2_reg.a_start_x, i2_reg.b_start_x, i2_reg.b_end_x)
              && in_span(i2_reg.a_start_y, i2_reg.b_start_y, i2_reg.b_end_y);
        hit = on_bs || on_be || on_as;
        priority if (on_bs)
        begin
            qx = i2_reg.b_start_x;
            qy = i2_reg.b_start_y;
        end
        else if (on_be)
        begin
            qx = i2_reg.b_end_x;
            qy = i2_reg.b_end_y;
        end
        else
        begin
            qx = i2_reg.a_start_x;
            qy = i2_reg.a_start_y;
        end
        edge_t = (tn_a == '0) || (tn_a == d_a) || (sn_a == '0) || (sn_a == d_a);

        job_next.divide  = 1'b0;
        job_next.outcome = segint_pkg::OUT_NONE;
        job_next.tn      = tn_a;
        job_next.d       = d_a;
        job_next.base_x  = i2_reg.a_start_x;
        job_next.base_y  = i2_reg.a_start_y;
        job_next.adx     = adx2_reg;
        job_next.ady     = ady2_reg;
        if (d_s == '0)
        begin
            job_next.base_x = qx;
            job_next.base_y = qy;
            job_next.adx    = '0;
            job_next.ady    = '0;
            if (hit)
            begin
                job_next.outcome = closed ? segint_pkg::OUT_SHARED
                                          : segint_pkg::OUT_REFUSED;
            end
        end
        else if (!(tn_a[CB-1] || sn_a[CB-1] || tn_a > d_a || sn_a > d_a))
        begin
            if (edge_t && !closed)
            begin
                job_next.outcome = segint_pkg::OUT_REFUSED;
            end
            else
            begin
                job_next.outcome = segint_pkg::OUT_CROSS;
                job_next.divide  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid <= 1'b0;
        end
        else
        begin
            job_valid <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        job <= job_next;
    end
endmodule
`default_nettype wire

### rtl/segint_back.sv
`default_nettype none
// Back: pipelined restoring divider, one quotient bit per stage, then the
// point multiply-add and saturation.
module segint_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 job_valid,
    input  wire segint_pkg::seg_job_t job,
    output logic                      res_valid,
    output segint_pkg::seg_out_t      res
);
    localparam int CB = segint_pkg::CrossBits;
    localparam int QB = segint_pkg::QuotBits;
    localparam int NS = segint_pkg::FracBits + 1;
    localparam int MB = segint_pkg::MulBits;
    localparam int SB = segint_pkg::SumBits;

    logic                  v_reg [NS+1];
    segint_pkg::seg_job_t  j_reg [NS+1];
    logic [CB:0]           r_reg [NS+1];
    logic [QB-1:0]         q_reg [NS+1];

    always_comb
    begin
        v_reg[0] = job_valid;
        j_reg[0] = job;
        r_reg[0] = {1'b0, job.tn};
        q_reg[0] = '0;
    end

    for (genvar s = 0; s < NS; s++) begin : g_div
        logic [CB:0]   rs;
        logic [QB-1:0] qs;
        always_comb
        begin
            rs = (s == 0) ? r_reg[s] : {r_reg[s][CB-1:0], 1'b0};
            qs = {q_reg[s][QB-2:0], 1'b0};
            if (rs >= {1'b0, j_reg[s].d})
            begin
                rs = rs - {1'b0, j_reg[s].d};
                qs[0] = 1'b1;
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end
        always_ff @(posedge clk)
        begin
            j_reg[s+1] <= j_reg[s];
            r_reg[s+1] <= rs;
            q_reg[s+1] <= qs;
        end
    end

    // round, multiply
    logic                 vm_reg;
    segint_pkg::seg_job_t jm_reg;
    logic signed [MB-1:0] mx_reg, my_reg;
    logic [QB-1:0]        qr;
    always_comb
    begin
        qr = q_reg[NS] + QB'({r_reg[NS][CB-1:0], 1'b0} >= {1'b0, j_reg[NS].d});
        if (!j_reg[NS].divide)
        begin
            qr = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
        end
        else
        begin
            vm_reg <= v_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        jm_reg <= j_reg[NS];
        mx_reg <= MB'($signed({1'b0, qr})) * MB'(j_reg[NS].adx);
        my_reg <= MB'($signed({1'b0, qr})) * MB'(j_reg[NS].ady);
    end

    function automatic logic signed [31:0] sat(input logic signed [SB-1:0] v);
        if (v > SB'(32'sh7fffffff))
            sat = 32'sh7fffffff;
        else if (v < SB'(32'sh80000000))
            sat = 32'sh80000000;
        else
            sat = v[31:0];
    endfunction

    logic signed [SB-1:0] sx, sy;
    segint_pkg::seg_out_t res_next;
    always_comb
    begin
        sx = (SB'(jm_reg.base_x) <<< segint_pkg::FracBits) + SB'(mx_reg);
        sy = (SB'(jm_reg.base_y) <<< segint_pkg::FracBits) + SB'(my_reg);
        res_next.outcome = jm_reg.outcome;
        res_next.point_x = '0;
        res_next.point_y = '0;
        if (jm_reg.outcome == segint_pkg::OUT_CROSS
            || jm_reg.outcome == segint_pkg::OUT_SHARED)
        begin
            res_next.point_x = sat(sx);
            res_next.point_y = sat(sy);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid <= 1'b0;
        end
        else
        begin
            res_valid <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        res <= res_next;
    end
endmodule
`default_nettype wire

### test/segment_intersection_tb.sv
`default_nettype none
module segment_intersection_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    segint_pkg::seg_in_t  item;
    logic                 done;
    segint_pkg::seg_out_t result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_data;

    segment_intersection DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Pipeline depth from accept to done; the drain waits add a margin to it.
    localparam int PipeDepth = 22;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Model copy of the one config register (closed_segments).
    logic                 closed_mode;
    segint_pkg::seg_in_t  pending_pairs[$];
    segint_pkg::seg_out_t expected_hits[$];
    int       error_count;
    int       results_seen;

    // Sender burst/gap control, and a hold flag used while reconfiguring.
    int       burst_left;
    int       gap_left;
    logic     hold_sender;

    // closed-segment test: point on segment, with both x and y bounds
    function automatic logic on_segment(longint px, longint py, longint sx, longint sy,
                                        longint ex, longint ey);
        longint cr;
        cr = (ex - sx) * (py - sy) - (ey - sy) * (px - sx);
        if (cr != 0)
            return 1'b0;
        return (px >= ((sx < ex) ? sx : ex)) && (px <= ((sx > ex) ? sx : ex)) &&
               (py >= ((sy < ey) ? sy : ey)) && (py <= ((sy > ey) ? sy : ey));
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Predicted intersection for one segment pair under the current mode.
    function automatic segint_pkg::seg_out_t intersect_pair(segint_pkg::seg_in_t p,
                                                            logic closed);
        segint_pkg::seg_out_t r;
        longint   asx, asy, aex, aey, bsx, bsy, bex, bey;
        longint   adx, ady, bdx, bdy, den, tn, sn, qx, qy, rem, quo;
        logic     hit;
        asx = longint'(p.a_start_x); asy = longint'(p.a_start_y);
        aex = longint'(p.a_end_x);   aey = longint'(p.a_end_y);
        bsx = longint'(p.b_start_x); bsy = longint'(p.b_start_y);
        bex = longint'(p.b_end_x);   bey = longint'(p.b_end_y);
        adx = aex - asx; ady = aey - asy;
        bdx = bex - bsx; bdy = bey - bsy;
        den = bdy * adx - bdx * ady;
        r.outcome = segint_pkg::OUT_NONE;
        r.point_x = '0;
        r.point_y = '0;
        if (den == 0)
        begin
            // parallel or degenerate: look for a shared point
            hit = 1'b1;
            qx = 0; qy = 0;
            if (on_segment(bsx, bsy, asx, asy, aex, aey))
            begin
                qx = bsx; qy = bsy;
            end
            else if (on_segment(bex, bey, asx, asy, aex, aey))
            begin
                qx = bex; qy = bey;
            end
            else if (on_segment(asx, asy, bsx, bsy, bex, bey))
            begin
                qx = asx; qy = asy;
            end
            else
                hit = 1'b0;
            if (hit && closed)
            begin
                r.outcome = segint_pkg::OUT_SHARED;
                r.point_x = clamp32(qx <<< segint_pkg::FracBits);
                r.point_y = clamp32(qy <<< segint_pkg::FracBits);
            end
            else if (hit)
                r.outcome = segint_pkg::OUT_REFUSED;
        end
        else
        begin
            tn = bdx * (asy - bsy) - bdy * (asx - bsx);
            sn = adx * (asy - bsy) - ady * (asx - bsx);
            if (den < 0)
            begin
                den = -den; tn = -tn; sn = -sn;
            end
            if (tn < 0 || sn < 0 || tn > den || sn > den)
                r.outcome = segint_pkg::OUT_NONE;
            else if ((tn == 0 || tn == den || sn == 0 || sn == den) && !closed)
                r.outcome = segint_pkg::OUT_REFUSED;
            else
            begin
                // t quantized to FracBits, half rounds up; exact in 64 bits
                quo = (tn <<< segint_pkg::FracBits) / den;
                rem = (tn <<< segint_pkg::FracBits) % den;
                if ((rem <<< 1) >= den)
                    quo = quo + 1;
                r.outcome = segint_pkg::OUT_CROSS;
                r.point_x = clamp32((asx <<< segint_pkg::FracBits) + quo * adx);
                r.point_y = clamp32((asy <<< segint_pkg::FracBits) + quo * ady);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch #%0d %s: got %0d want %0d", results_seen, what, got, want);
        error_count++;
    endtask

    // Driver: pops the pending queue in bursts with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            item       <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            // current transaction taken at this edge? then refill or drop start
            if (!start || !busy)
            begin
                if (hold_sender || pending_pairs.size() == 0)
                    start <= 1'b0;
                else if (gap_left > 0)
                begin
                    start    <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else
                begin
                    start <= 1'b1;
                    item  <= pending_pairs[0];
                    expected_hits.push_back(intersect_pair(pending_pairs[0], closed_mode));
                    void'(pending_pairs.pop_front());
                    if (burst_left <= 1)
                    begin
                        // new burst; sometimes a long stretch with no gaps
                        burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                                  : $urandom_range(1, 12);
                        gap_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Monitor: compares each done strobe against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_hits.size() == 0)
                report_mismatch("unexpected result", result.outcome, -1);
            else
            begin
                if (result.outcome !== expected_hits[0].outcome)
                    report_mismatch("outcome", result.outcome, expected_hits[0].outcome);
                if (result.point_x !== expected_hits[0].point_x)
                    report_mismatch("point_x", result.point_x, expected_hits[0].point_x);
                if (result.point_y !== expected_hits[0].point_y)
                    report_mismatch("point_y", result.point_y, expected_hits[0].point_y);
                void'(expected_hits.pop_front());
            end
        end
    end

    function automatic logic signed [15:0] rnd_coord(int span);
        if (span >= 32768)
            return 16'($urandom());
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic segint_pkg::seg_in_t make_pair(int ax, int ay, int bx, int by,
                                                      int cx, int cy, int ex, int ey);
        segint_pkg::seg_in_t p;
        p.a_start_x = 16'(ax); p.a_start_y = 16'(ay);
        p.a_end_x   = 16'(bx); p.a_end_y   = 16'(by);
        p.b_start_x = 16'(cx); p.b_start_y = 16'(cy);
        p.b_end_x   = 16'(ex); p.b_end_y   = 16'(ey);
        return p;
    endfunction

    // Random pair, weighted toward touches, collinear cases and point segments.
    function automatic segint_pkg::seg_in_t random_pair();
        segint_pkg::seg_in_t p;
        int      span, k, m;
        span = ($urandom_range(0, 3) == 0) ? 32768 : (1 << $urandom_range(2, 14));
        p.a_start_x = rnd_coord(span); p.a_start_y = rnd_coord(span);
        p.a_end_x   = rnd_coord(span); p.a_end_y   = rnd_coord(span);
        p.b_start_x = rnd_coord(span); p.b_start_y = rnd_coord(span);
        p.b_end_x   = rnd_coord(span); p.b_end_y   = rnd_coord(span);
        case ($urandom_range(0, 5))
            0:
            begin
                // B starts on an endpoint of A
                p.b_start_x = p.a_end_x; p.b_start_y = p.a_end_y;
            end
            1:
            begin
                // collinear: both on a line through a_start along a small step
                k = int'($urandom_range(1, 7)); m = int'($urandom_range(0, 7)) - 3;
                p.a_start_x = rnd_coord(1000); p.a_start_y = rnd_coord(1000);
                p.a_end_x = 16'(p.a_start_x + k * 20);
                p.a_end_y = 16'(p.a_start_y + m * 20);
                p.b_start_x = 16'(p.a_start_x + k * (int'($urandom_range(0, 60)) - 20));
                p.b_start_y = 16'(p.a_start_y + m * (p.b_start_x - p.a_start_x) / k);
                p.b_end_x = 16'(p.b_start_x + k * (int'($urandom_range(0, 30)) - 15));
                p.b_end_y = 16'(p.b_start_y + m * (p.b_end_x - p.b_start_x) / k);
            end
            2:
            begin
                // degenerate point segment
                p.b_end_x = p.b_start_x; p.b_end_y = p.b_start_y;
            end
            default: ;
        endcase
        return p;
    endfunction

    // Waits for the pipe to drain, then writes the mode register.
    task automatic set_mode(logic value);
        while (pending_pairs.size() != 0 || start)
            @(posedge clk);
        hold_sender = 1'b1;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (PipeDepth + 4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        closed_mode = value;
        hold_sender = 1'b0;
    endtask

    task automatic queue_directed();
        pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 10, 10, 0));      // plain cross
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 10, 0, 10, 10));      // endpoint touch
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 5, 10));        // T on A interior
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 1, 10, 1));        // parallel apart
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 20, 0));        // overlap, b_start on A
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 20, 0, 5, 0));        // b_end on A
        pending_pairs.push_back(make_pair(2, 0, 4, 0, 0, 0, 10, 0));         // A inside B
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 11, 0, 20, 0));       // collinear disjoint
        pending_pairs.push_back(make_pair(0, 0, 10, 10, 11, 11, 20, 20));    // diag disjoint
        pending_pairs.push_back(make_pair(3, 3, 3, 3, 0, 0, 6, 6));          // point on B
        pending_pairs.push_back(make_pair(3, 3, 3, 3, 3, 3, 3, 3));          // both points
        pending_pairs.push_back(make_pair(0, 0, 3, 0, 1, -1, 2, 1));         // crossing at A's midpoint
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 20, -5, 20, 5));      // t beyond 1
        pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                          -32768, 32767, 32767, -32768));   // full range X
        pending_pairs.push_back(make_pair(32767, -32768, -32768, 32767,
                                          32767, 32767, -32768, -32768));
        pending_pairs.push_back(make_pair(-32768, 0, 32767, 0,
                                          0, -32768, 0, 32767));
        pending_pairs.push_back(make_pair(-32768, -32768, 32767, -32768,
                                          -32768, -32768, -32768, 32767));  // corner touch
        pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
        pending_pairs.push_back(make_pair(0, 0, 1, 32767, 0, 32767, 1, 0));
    endtask

    int n;

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        closed_mode   = 1'b1;
        hold_sender   = 1'b0;
        error_count   = 0;
        results_seen  = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset mode (closed), then open, then closed again via a write
        queue_directed();
        set_mode(1'b0);
        queue_directed();
        set_mode(1'b1);
        queue_directed();

        for (n = 0; n < 1100; n++)
        begin
            pending_pairs.push_back(random_pair());
            if (n == 300)
                set_mode(1'b1);   // pause until drained, mode unchanged
            if (n == 550)
                set_mode(1'b0);
            if (n == 850)
                set_mode(1'b1);
        end

        while (pending_pairs.size() != 0 || start)
            @(posedge clk);
        n = 0;
        while (expected_hits.size() != 0 && n < 1000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (PipeDepth + 4) @(posedge clk);
        if (error_count == 0 && expected_hits.size() == 0)
            $display("segment_intersection_tb: done, clean");
        else
            $display("segment_intersection_tb: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2ms;
        $display("segment_intersection_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
